// File: rtl/core/flrc_pkg.sv
`default_nettype none
package flrc_pkg;

    localparam int TABLE_DEPTH  = 16384;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
    localparam int IMAGE_WIDTH  = 720;
    localparam int IMAGE_HEIGHT = 480;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Radicand of the radius square root and the root it gives.
    localparam int SQ_W        = 57;
    localparam int RU_W        = 29;
    localparam int SQRT_STEPS  = 29;

    localparam int CORDIC_STEPS = 22;
    localparam int XY_W         = 34;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;
    localparam int ANGLE_W      = 23;
    localparam int ANGLE_MAX    = 90 * 65536;

    localparam int RD_W      = 36;
    localparam int MAG_W     = 40;
    localparam int DIV_STEPS = MAG_W;

    localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_FOCAL,
        CFG_ELLIPSE,
        CFG_INV_ELLIPSE,
        CFG_INV_PIXEL,
        CFG_ENTRIES_PER_DEG
    } cfg_index_t;

    // Per-transaction information that travels beside the arithmetic.
    typedef struct packed {
        logic            valid;
        logic            is_map;
        logic [13:0]     load_index;
        logic [31:0]     load_value;
        logic [11:0]     adx;
        logic [11:0]     ady;
        logic            dx_pos;
        logic            dy_pos;
        logic [RU_W-1:0] ru;
        logic            sat_x;
        logic            sat_y;
    } side_t;

endpackage
`default_nettype wire

// File: rtl/core/flrc_sqrt_cell.sv
`default_nettype none
module flrc_sqrt_cell (
    input  wire                       clk,
    input  wire                       en,
    input  wire  [flrc_pkg::SQ_W-1:0] bit_weight,
    input  wire  [flrc_pkg::SQ_W-1:0] v_in,
    input  wire  [flrc_pkg::SQ_W-1:0] res_in,
    output logic [flrc_pkg::SQ_W-1:0] v_out,
    output logic [flrc_pkg::SQ_W-1:0] res_out
);
    import flrc_pkg::*;

    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] v_next;
    logic [SQ_W-1:0] res_next;

    always_comb
    begin
        trial = {1'b0, res_in} + {1'b0, bit_weight};
        if ({1'b0, v_in} >= trial)
        begin
            v_next   = v_in - trial[SQ_W-1:0];
            res_next = (res_in >> 1) + bit_weight;
        end
        else
        begin
            v_next   = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_out   <= v_next;
            res_out <= res_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/flrc_cordic_cell.sv
`default_nettype none
module flrc_cordic_cell (
    input  wire                                clk,
    input  wire                                en,
    input  wire         [4:0]                  shift,
    input  wire         [flrc_pkg::ATAN_W-1:0] atan,
    input  wire  signed [flrc_pkg::XY_W-1:0]   x_in,
    input  wire  signed [flrc_pkg::XY_W-1:0]   y_in,
    input  wire  signed [flrc_pkg::Z_W-1:0]    z_in,
    output logic signed [flrc_pkg::XY_W-1:0]   x_out,
    output logic signed [flrc_pkg::XY_W-1:0]   y_out,
    output logic signed [flrc_pkg::Z_W-1:0]    z_out
);
    import flrc_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  a;

    assign xs = x_in >>> shift;
    assign ys = y_in >>> shift;
    assign a  = $signed({{(Z_W-ATAN_W){1'b0}}, atan});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[XY_W-1])
            begin
                x_out <= x_in + ys;
                y_out <= y_in - xs;
                z_out <= z_in + a;
            end
            else
            begin
                x_out <= x_in - ys;
                y_out <= y_in + xs;
                z_out <= z_in - a;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/flrc_div_cell.sv
`default_nettype none
module flrc_div_cell (
    input  wire                        clk,
    input  wire                        en,
    input  wire  [flrc_pkg::RU_W-1:0]  divisor,
    input  wire  [flrc_pkg::RU_W-1:0]  rem_in,
    input  wire  [flrc_pkg::MAG_W-1:0] low_in,
    input  wire  [flrc_pkg::MAG_W-1:0] q_in,
    output logic [flrc_pkg::RU_W-1:0]  rem_out,
    output logic [flrc_pkg::MAG_W-1:0] low_out,
    output logic [flrc_pkg::MAG_W-1:0] q_out
);
    import flrc_pkg::*;

    logic [RU_W:0] t;
    logic          ge;

    assign t  = {rem_in, low_in[MAG_W-1]};
    assign ge = t >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= ge ? RU_W'(t - {1'b0, divisor}) : t[RU_W-1:0];
            low_out <= low_in << 1;
            q_out   <= {q_in[MAG_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/fisheye_lut_remap_coordinate_unit.sv
`default_nettype none
// Channel   | Direction | Contents
// s_axis    | in        | tuser: operation; tdata: table_index, table_value, dest_col, dest_row
// m_axis    | out       | tdata: src_col, src_row
// cfg       | in        | register write, index as listed, no read-back
//
// One transaction is taken per clock while the pipe advances; each map
// transaction gives one result. The pipe holds the 29-cell square root,
// the 22-cell CORDIC and the 40-cell divider rows. Table loads travel the same
// pipe and write the table at the stage where maps read it, so order holds.
// A stalled result stalls the pipe only when it would be overwritten; reset
// clears the valid flags and loads the default settings, but not the table.
module fisheye_lut_remap_coordinate_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [71:0]                        s_axis_tdata, // table_index, table_value, dest_col, dest_row
    input  wire  [0:0]                         s_axis_tuser, // operation
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [23:0]                        m_axis_tdata, // src_col, src_row
    input  wire                                cfg_we,
    input  wire  [flrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [flrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import flrc_pkg::*;

    logic [11:0] center_x_reg, center_y_reg;
    logic [19:0] focal_reg;
    logic [15:0] ellipse_reg, inv_ellipse_reg;
    logic [23:0] inv_pixel_reg, epd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= 12'd360;
            center_y_reg    <= 12'd240;
            focal_reg       <= 20'd41434;
            ellipse_reg     <= 16'd18432;
            inv_ellipse_reg <= 16'd14564;
            inv_pixel_reg   <= 24'd42667;
            epd_reg         <= 24'd6553600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER_X:        center_x_reg    <= cfg_data[11:0];
                CFG_CENTER_Y:        center_y_reg    <= cfg_data[11:0];
                CFG_FOCAL:           focal_reg       <= cfg_data[19:0];
                CFG_ELLIPSE:         ellipse_reg     <= cfg_data[15:0];
                CFG_INV_ELLIPSE:     inv_ellipse_reg <= cfg_data[15:0];
                CFG_INV_PIXEL:       inv_pixel_reg   <= cfg_data;
                CFG_ENTRIES_PER_DEG: epd_reg         <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Pipeline advance and output register.
    logic  adv;
    logic  out_take;
    side_t side_o;
    logic  out_valid_reg;
    logic [23:0] out_data_reg;
    logic [11:0] col_res, row_res;

    assign out_take      = !out_valid_reg || m_axis_tready;
    assign adv           = out_take || !(side_o.valid && side_o.is_map);
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Stage A: offsets from the centre.
    side_t side_a, side_b, side_c, side_d;
    side_t side_in;
    logic signed [12:0] dx, dy;

    always_comb
    begin
        dx = $signed({1'b0, s_axis_tdata[57:46]}) - $signed({1'b0, center_x_reg});
        dy = $signed({1'b0, s_axis_tdata[69:58]}) - $signed({1'b0, center_y_reg});
        side_in            = '0;
        side_in.valid      = s_axis_tvalid;
        side_in.is_map     = s_axis_tuser[0];
        side_in.load_index = s_axis_tdata[13:0];
        side_in.load_value = s_axis_tdata[45:14];
        side_in.adx        = dx[12] ? 12'(-dx) : dx[11:0];
        side_in.ady        = dy[12] ? 12'(-dy) : dy[11:0];
        side_in.dx_pos     = !dx[12] && (dx != 13'sd0);
        side_in.dy_pos     = !dy[12] && (dy != 13'sd0);
    end

    logic [27:0] hx_b, vy_b;
    logic [55:0] hx2_c, vy2_c;
    logic [SQ_W-1:0] sum_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_a <= '0;
            side_b <= '0;
            side_c <= '0;
            side_d <= '0;
        end
        else if (adv)
        begin
            side_a <= side_in;
            side_b <= side_a;
            side_c <= side_b;
            side_d <= side_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hx_b  <= side_a.adx * inv_ellipse_reg;
            vy_b  <= {2'b0, side_a.ady, 14'b0};
            hx2_c <= hx_b * hx_b;
            vy2_c <= vy_b * vy_b;
            sum_d <= {1'b0, hx2_c} + {1'b0, vy2_c};
        end
    end

    // Square root: one result bit per cell.
    side_t           sside  [SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_v   [SQRT_STEPS+1];
    logic [SQ_W-1:0] sq_res [SQRT_STEPS+1];

    assign sside[0]  = side_d;
    assign sq_v[0]   = sum_d;
    assign sq_res[0] = '0;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        flrc_sqrt_cell u_cell (
            .clk        (clk),
            .en         (adv),
            .bit_weight (SQ_W'(1) << (2 * (SQRT_STEPS - 1 - i))),
            .v_in       (sq_v[i]),
            .res_in     (sq_res[i]),
            .v_out      (sq_v[i+1]),
            .res_out    (sq_res[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sside[i+1] <= '0;
            else if (adv)
                sside[i+1] <= sside[i];
        end
    end

    // CORDIC vectoring: view angle in degrees.
    side_t                  cside [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cx    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cy    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cz    [CORDIC_STEPS+1];

    always_comb
    begin
        cside[0]    = sside[SQRT_STEPS];
        cside[0].ru = sq_res[SQRT_STEPS][RU_W-1:0];
    end

    assign cx[0] = $signed({{(XY_W-26){1'b0}}, focal_reg, 6'b0});
    assign cy[0] = $signed({{(XY_W-RU_W){1'b0}}, sq_res[SQRT_STEPS][RU_W-1:0]});
    assign cz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        flrc_cordic_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .shift (5'(i)),
            .atan  (ATAN_DEG_Q16[i]),
            .x_in  (cx[i]),
            .y_in  (cy[i]),
            .z_in  (cz[i]),
            .x_out (cx[i+1]),
            .y_out (cy[i+1]),
            .z_out (cz[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cside[i+1] <= '0;
            else if (adv)
                cside[i+1] <= cside[i];
        end
    end

    // Angle clamp, table position, table read and interpolation.
    side_t side_e, side_f, side_g, side_h, side_i, side_j, side_k, side_l;
    logic [ANGLE_W-1:0] angle_e;
    logic [46:0]        pos_f;
    logic [14:0]        k_f;
    logic               sat_f;
    logic [TABLE_AW-1:0] addr0, addr1;
    logic [31:0]        t0_g, t1_g;
    logic [15:0]        fr_g;
    logic [31:0]        radius_mem [TABLE_DEPTH];
    logic signed [49:0] prod_h;
    logic [31:0]        t0_h;
    logic [31:0]        rt_i;
    logic [55:0]        rp_j;
    logic [RD_W-1:0]    rd_k;
    logic [47:0]        nx_l, ny_l;
    logic signed [Z_W-1:0] zf;
    logic signed [49:0] ip_sum;

    assign zf    = cz[CORDIC_STEPS];
    assign k_f   = pos_f[46:32];
    assign sat_f = 32'(k_f) >= TABLE_DEPTH - 1;
    assign addr0 = sat_f ? TABLE_AW'(TABLE_DEPTH - 1) : TABLE_AW'(k_f);
    assign addr1 = TABLE_AW'(k_f + 15'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_e <= '0;
            side_f <= '0;
            side_g <= '0;
            side_h <= '0;
            side_i <= '0;
            side_j <= '0;
            side_k <= '0;
            side_l <= '0;
        end
        else if (adv)
        begin
            side_e <= cside[CORDIC_STEPS];
            side_f <= side_e;
            side_g <= side_f;
            side_h <= side_g;
            side_i <= side_h;
            side_j <= side_i;
            side_k <= side_j;
            side_l <= side_k;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zf[Z_W-1])
                angle_e <= '0;
            else if (32'(zf) > ANGLE_MAX)
                angle_e <= ANGLE_W'(ANGLE_MAX);
            else
                angle_e <= zf[ANGLE_W-1:0];
            pos_f <= angle_e * epd_reg;
            fr_g  <= sat_f ? 16'd0 : pos_f[31:16];
        end
    end

    // The table is written and read at one stage so loads and maps keep order.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (side_f.valid && !side_f.is_map && (32'(side_f.load_index) < TABLE_DEPTH))
                radius_mem[TABLE_AW'(side_f.load_index)] <= side_f.load_value;
            t0_g <= radius_mem[addr0];
            t1_g <= radius_mem[addr1];
        end
    end

    assign ip_sum = $signed({18'b0, t0_h}) + (prod_h >>> 16);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_h <= ($signed({1'b0, t1_g}) - $signed({1'b0, t0_g}))
                      * $signed({1'b0, fr_g});
            t0_h   <= t0_g;
            rt_i   <= ip_sum[31:0];
            rp_j   <= rt_i * inv_pixel_reg;
            rd_k   <= (|rp_j[55:52]) ? {RD_W{1'b1}} : rp_j[51:16];
            nx_l   <= rd_k * side_k.adx;
            ny_l   <= rd_k * side_k.ady;
        end
    end

    // Split of the radius: two rows of restoring division cells.
    side_t            dside [DIV_STEPS+1];
    side_t            side_m_next;
    logic [RU_W-1:0]  xrem [DIV_STEPS+1];
    logic [RU_W-1:0]  yrem [DIV_STEPS+1];
    logic [MAG_W-1:0] xlow [DIV_STEPS+1];
    logic [MAG_W-1:0] ylow [DIV_STEPS+1];
    logic [MAG_W-1:0] xq   [DIV_STEPS+1];
    logic [MAG_W-1:0] yq   [DIV_STEPS+1];
    logic [61:0]      numx, numy;

    assign numx = {nx_l, 14'b0};
    assign numy = {ny_l, 14'b0};

    always_comb
    begin
        side_m_next       = side_l;
        side_m_next.sat_x = {7'b0, numx[61:40]} >= side_l.ru;
        side_m_next.sat_y = {7'b0, numy[61:40]} >= side_l.ru;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dside[0] <= '0;
        else if (adv)
            dside[0] <= side_m_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xrem[0] <= {7'b0, numx[61:40]};
            yrem[0] <= {7'b0, numy[61:40]};
            xlow[0] <= numx[39:0];
            ylow[0] <= numy[39:0];
            xq[0]   <= '0;
            yq[0]   <= '0;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        flrc_div_cell u_xcell (
            .clk     (clk),
            .en      (adv),
            .divisor (dside[i].ru),
            .rem_in  (xrem[i]),
            .low_in  (xlow[i]),
            .q_in    (xq[i]),
            .rem_out (xrem[i+1]),
            .low_out (xlow[i+1]),
            .q_out   (xq[i+1])
        );

        flrc_div_cell u_ycell (
            .clk     (clk),
            .en      (adv),
            .divisor (dside[i].ru),
            .rem_in  (yrem[i]),
            .low_in  (ylow[i]),
            .q_in    (yq[i]),
            .rem_out (yrem[i+1]),
            .low_out (ylow[i+1]),
            .q_out   (yq[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dside[i+1] <= '0;
            else if (adv)
                dside[i+1] <= dside[i];
        end
    end

    // Saturation, ellipse scaling, centre offset and clamp.
    side_t            side_n;
    side_t            side_d_last;
    logic [MAG_W-1:0] xm_n, ym_n, ym_o;
    logic [55:0]      px_o;
    logic             zero_ru;

    assign side_d_last = dside[DIV_STEPS];
    assign zero_ru     = side_d_last.ru == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_n <= '0;
            side_o <= '0;
        end
        else if (adv)
        begin
            side_n <= side_d_last;
            side_o <= side_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zero_ru)
            begin
                xm_n <= '0;
                ym_n <= '0;
            end
            else
            begin
                xm_n <= side_d_last.sat_x ? {MAG_W{1'b1}} : xq[DIV_STEPS];
                ym_n <= side_d_last.sat_y ? {MAG_W{1'b1}} : yq[DIV_STEPS];
            end
            px_o <= xm_n * ellipse_reg;
            ym_o <= ym_n;
        end
    end

    logic signed [57:0] vc;
    logic signed [41:0] vr;

    always_comb
    begin
        if (side_o.dx_pos)
            vc = $signed({16'b0, center_x_reg, 30'b0}) + $signed({2'b0, px_o});
        else
            vc = $signed({16'b0, center_x_reg, 30'b0}) - $signed({2'b0, px_o});
        if (side_o.dy_pos)
            vr = $signed({14'b0, center_y_reg, 16'b0}) + $signed({2'b0, ym_o});
        else
            vr = $signed({14'b0, center_y_reg, 16'b0}) - $signed({2'b0, ym_o});

        if (vc[57])
            col_res = '0;
        else if (32'(vc[57:30]) > IMAGE_WIDTH - 1)
            col_res = 12'(IMAGE_WIDTH - 1);
        else
            col_res = vc[41:30];

        if (vr[41])
            row_res = '0;
        else if (32'(vr[41:16]) > IMAGE_HEIGHT - 1)
            row_res = 12'(IMAGE_HEIGHT - 1);
        else
            row_res = vr[27:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_take)
            out_valid_reg <= side_o.valid && side_o.is_map;
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
            out_data_reg <= {row_res, col_res};
    end

endmodule
`default_nettype wire

// File: bench/tb_fisheye_lut_remap_coordinate_unit.sv
`timescale 1ns / 1ps
module tb_fisheye_lut_remap_coordinate_unit;
    import flrc_pkg::*;

    localparam int PIPE_LATENCY = 107;
    localparam int FILL_ENTRIES = 64;
    // An entry step that keeps every table position of a 90 degree
    // angle below the filled entries.
    localparam int EPD_LIMIT    = 45000;

    typedef struct {
        bit          is_map;
        logic [13:0] idx;
        logic [31:0] value;
        logic [11:0] col;
        logic [11:0] row;
        bit          typed;
        logic [11:0] exp_col;
        logic [11:0] exp_row;
    } stim_row_t;

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
    } src_pixel_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [0:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model copy of the registers and the radius table.
    logic [63:0] m_cx, m_cy, m_focal, m_ell, m_inv_ell, m_inv_pix, m_epd;
    logic [31:0] radius_lut [TABLE_DEPTH];

    src_pixel_t pending_src[$];
    int error_count = 0;
    int idle_pct = 9;
    int rx_hold = 0;

    fisheye_lut_remap_coordinate_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
            error_count++;
        end
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        end
    endfunction

    function automatic longint view_angle_q16(input logic [63:0] ru);
        longint x, y, z, xs, ys;
        begin
            x = longint'(m_focal << 6);
            y = longint'(ru);
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(ATAN_DEG_Q16[i]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(ATAN_DEG_Q16[i]);
                end
            end
            if (z < 0)
                z = 0;
            if (z > ANGLE_MAX)
                z = ANGLE_MAX;
            return z;
        end
    endfunction

    function automatic logic [63:0] lut_radius(input longint angle);
        logic [63:0] pos, k;
        longint fr, t0, t1;
        begin
            pos = 64'(angle) * m_epd;
            k = pos >> 32;
            fr = longint'((pos >> 16) & 64'hFFFF);
            if (k >= TABLE_DEPTH - 1)
                return 64'(radius_lut[TABLE_DEPTH-1]);
            t0 = longint'({32'd0, radius_lut[k]});
            t1 = longint'({32'd0, radius_lut[k+1]});
            return 64'(t0 + (((t1 - t0) * fr) >>> 16));
        end
    endfunction

    function automatic logic [11:0] clamp_pixel(input longint v, input int frac,
                                                input longint limit);
        longint c;
        begin
            if (v < 0)
                return 12'd0;
            c = v >>> frac;
            return (c > limit) ? 12'(limit) : 12'(c);
        end
    endfunction

    function automatic src_pixel_t map_to_source(input logic [11:0] col,
                                                 input logic [11:0] row);
        longint dx, dy, cv, rv;
        logic [63:0] adx, ady, hx, vy, ru, rd, xm, ym;
        src_pixel_t p;
        begin
            dx = longint'({52'd0, col}) - longint'(m_cx);
            dy = longint'({52'd0, row}) - longint'(m_cy);
            adx = 64'(dx < 0 ? -dx : dx);
            ady = 64'(dy < 0 ? -dy : dy);
            hx = adx * m_inv_ell;
            vy = ady << 14;
            ru = int_sqrt(hx * hx + vy * vy);
            xm = 0;
            ym = 0;
            if (ru != 0)
            begin
                rd = (lut_radius(view_angle_q16(ru)) * m_inv_pix) >> 16;
                if (rd > (64'd1 << RD_W) - 1)
                    rd = (64'd1 << RD_W) - 1;
                xm = rd * (adx << 14) / ru;
                ym = rd * (ady << 14) / ru;
                if (xm > (64'd1 << MAG_W) - 1)
                    xm = (64'd1 << MAG_W) - 1;
                if (ym > (64'd1 << MAG_W) - 1)
                    ym = (64'd1 << MAG_W) - 1;
            end
            cv = longint'(xm * m_ell);
            if (dx <= 0)
                cv = -cv;
            cv = cv + longint'(m_cx << 30);
            rv = longint'(ym);
            if (dy <= 0)
                rv = -rv;
            rv = rv + longint'(m_cy << 16);
            p.col = clamp_pixel(cv, 30, IMAGE_WIDTH - 1);
            p.row = clamp_pixel(rv, 16, IMAGE_HEIGHT - 1);
            return p;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input bit is_map, input logic [13:0] idx,
                             input logic [31:0] value, input logic [11:0] col,
                             input logic [11:0] row, input bit typed = 0,
                             input logic [11:0] exp_col = 0,
                             input logic [11:0] exp_row = 0);
        src_pixel_t p;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                s_axis_tvalid = 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tuser = is_map;
            s_axis_tdata = {2'b00, row, col, value, idx};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            if (is_map)
            begin
                p = map_to_source(col, row);
                if (typed)
                begin
                    p.col = exp_col;
                    p.row = exp_row;
                end
                pending_src = {pending_src, p};
            end
            else
                radius_lut[idx] = value;
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
        begin
            cfg_we = 1'b1;
            cfg_index = idx;
            cfg_data = value;
            case (idx)
                CFG_CENTER_X: m_cx = value & 24'hFFF;
                CFG_CENTER_Y: m_cy = value & 24'hFFF;
                CFG_FOCAL: m_focal = value & 24'hFFFFF;
                CFG_ELLIPSE: m_ell = value & 24'hFFFF;
                CFG_INV_ELLIPSE: m_inv_ell = value & 24'hFFFF;
                CFG_INV_PIXEL: m_inv_pix = value;
                CFG_ENTRIES_PER_DEG: m_epd = value;
                default: ;
            endcase
            @(negedge clk);
            cfg_we = 1'b0;
        end
    endtask

    // Loads give no result, so the pipe is given its full latency to empty.
    task automatic wait_drained();
        begin
            while (pending_src.size() != 0)
                @(posedge clk);
            repeat (PIPE_LATENCY + 20) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic load_settings(input logic [23:0] cx, input logic [23:0] cy,
                                 input logic [23:0] f, input logic [23:0] el,
                                 input logic [23:0] iel, input logic [23:0] ipx,
                                 input logic [23:0] epd);
        begin
            write_reg(CFG_CENTER_X, cx);
            write_reg(CFG_CENTER_Y, cy);
            write_reg(CFG_FOCAL, f);
            write_reg(CFG_ELLIPSE, el);
            write_reg(CFG_INV_ELLIPSE, iel);
            write_reg(CFG_INV_PIXEL, ipx);
            write_reg(CFG_ENTRIES_PER_DEG, epd);
        end
    endtask

    task automatic random_items(input int count);
        logic [11:0] c, r;
        begin
            // The optical centre itself is mapped once per setting.
            send_item(1'b1, 14'($urandom), $urandom, 12'(m_cx), 12'(m_cy));
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 99) < 20)
                begin
                    send_item(1'b0, 14'($urandom), $urandom, 12'($urandom), 12'($urandom));
                end
                else
                begin
                    c = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 719));
                    r = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 479));
                    send_item(1'b1, 14'($urandom), $urandom, c, r);
                end
            end
        end
    endtask

    // Result checker and receiver backpressure.
    always @(posedge clk)
    begin
        src_pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_src.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else
            begin
                want = pending_src.pop_front();
                if (m_axis_tdata[11:0] !== want.col)
                    report_mismatch($sformatf("src_col %0d, want %0d",
                                              m_axis_tdata[11:0], want.col));
                if (m_axis_tdata[23:12] !== want.row)
                    report_mismatch($sformatf("src_row %0d, want %0d",
                                              m_axis_tdata[23:12], want.row));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    stim_row_t directed[] = '{
        '{1, 0, 0, 360, 240, 1, 360, 240},
        '{1, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 4095, 4095, 0, 0, 0},
        '{1, 0, 0, 0, 4095, 0, 0, 0},
        '{1, 0, 0, 4095, 0, 0, 0, 0},
        '{1, 0, 0, 719, 479, 0, 0, 0},
        '{1, 0, 0, 360, 0, 0, 0, 0},
        '{1, 0, 0, 0, 240, 0, 0, 0},
        '{1, 0, 0, 4095, 240, 0, 0, 0},
        '{1, 0, 0, 360, 4095, 0, 0, 0},
        '{1, 0, 0, 361, 240, 0, 0, 0},
        '{1, 0, 0, 360, 241, 0, 0, 0},
        '{1, 0, 0, 359, 239, 0, 0, 0},
        '{0, 0, 32'h0000_0000, 0, 0, 0, 0, 0},
        '{0, 16383, 32'hFFFF_FFFF, 4095, 4095, 0, 0, 0},
        '{0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
        '{1, 0, 0, 361, 241, 0, 0, 0},
        '{1, 0, 0, 4095, 4095, 0, 0, 0},
        '{0, 1, 32'd40000, 0, 0, 0, 0, 0}
    };

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_cx = 360;
        m_cy = 240;
        m_focal = 41434;
        m_ell = 18432;
        m_inv_ell = 14564;
        m_inv_pix = 42667;
        m_epd = 6553600;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Maps only ever read the low entries written here, or the last entry
        // once the position runs past the end of the table.
        write_reg(CFG_ENTRIES_PER_DEG, 24'(EPD_LIMIT));
        idle_pct = 0;
        for (int i = 0; i < FILL_ENTRIES; i++)
            send_item(1'b0, 14'(i), 32'(i * 40000 + $urandom_range(0, 999)), 0, 0);
        send_item(1'b0, 14'(TABLE_DEPTH - 1), 32'((TABLE_DEPTH - 1) * 40000), 0, 0);
        idle_pct = 9;

        foreach (directed[i])
            send_item(directed[i].is_map, directed[i].idx, directed[i].value,
                      directed[i].col, directed[i].row, directed[i].typed,
                      directed[i].exp_col, directed[i].exp_row);

        random_items(60);

        // The receiver stalls long enough for the pipe to fill and push back.
        wait_drained();
        load_settings(0, 0, 1, 1, 1, 1, 1);
        rx_hold = 400;
        random_items(150);

        wait_drained();
        load_settings(4095, 4095, 24'hFFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFFFF,
                      24'(EPD_LIMIT));
        random_items(30);

        // A focal length of one puts every offset pixel near 90 degrees, so
        // the table position runs past the end for every pixel but the centre.
        wait_drained();
        load_settings(360, 240, 1, 18432, 24'hFFFF, 42667, 24'hFFFFFF);
        random_items(30);

        wait_drained();
        idle_pct = 0;
        load_settings(360, 240, 41434, 18432, 14564, 42667, 24'(EPD_LIMIT));
        random_items(30);
        idle_pct = 9;

        for (int ph = 0; ph < 3; ph++)
        begin
            wait_drained();
            load_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(1, 24'hFFFFF), $urandom_range(1, 24'hFFFF),
                          $urandom_range(1, 24'hFFFF), $urandom_range(1, 24'hFFFFFF),
                          $urandom_range(1, EPD_LIMIT));
            random_items(20);
        end

        wait_drained();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/flrc_pkg.sv
rtl/core/flrc_sqrt_cell.sv
rtl/core/flrc_cordic_cell.sv
rtl/core/flrc_div_cell.sv
rtl/core/fisheye_lut_remap_coordinate_unit.sv
bench/tb_fisheye_lut_remap_coordinate_unit.sv
